### hw/rtl/int_hash_set_probe_engine_defines.svh
// Assertion macros for the hash set probe engine.
// Used by modules that include this header; relies on clk and rst in scope.
`ifndef INT_HASH_SET_PROBE_ENGINE_DEFINES_SVH
`define INT_HASH_SET_PROBE_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define HSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/hsp_pkg.sv
// Package for the hash set probe engine: word types, codes and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hsp_pkg;

  localparam int CFG_W = 11;

  localparam logic [1:0] CFG_HASH_MODE  = 2'd0;
  localparam logic [1:0] CFG_SLOT_COUNT = 2'd1;
  localparam logic [1:0] CFG_LOAD_LIMIT = 2'd2;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] ST_INSERTED    = 2'd0;
  localparam logic [1:0] ST_PRESENT     = 2'd1;
  localparam logic [1:0] ST_NOT_PRESENT = 2'd2;
  localparam logic [1:0] ST_FULL        = 2'd3;

  localparam logic [1:0] HM_LOOKUP3 = 2'd0;
  localparam logic [1:0] HM_MURMUR  = 2'd1;
  localparam logic [1:0] HM_MULADD  = 2'd2;

  localparam logic [31:0] LK3_INIT  = 32'h9e3779b9 + 32'd3923099;
  localparam logic [31:0] MUR_C1    = 32'h85ebca6b;
  localparam logic [31:0] MUR_C2    = 32'hc2b2ae35;
  localparam logic [31:0] MA_MUL    = 32'd7691;
  localparam logic [31:0] MA_ADD    = 32'd4201;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
  } hsp_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] element_count;
    logic [31:0] set_signature;
    logic [31:0] collision_total;
  } hsp_result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SWEEP, S_LOAD, S_HASH, S_MOD, S_STRIDE, S_READ, S_CHECK
  } hsp_state_t;

  function automatic logic [4:0] lk3_rot(input logic [2:0] step);
    logic [4:0] r;
    unique case (step)
      3'd0:    r = 5'd14;
      3'd1:    r = 5'd11;
      3'd2:    r = 5'd25;
      3'd3:    r = 5'd16;
      3'd4:    r = 5'd4;
      3'd5:    r = 5'd14;
      3'd6:    r = 5'd24;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/hsp_hash.sv
// Iterative key hash: one shared mix/rotate unit and one multiplier stepped
// by a counter. Depends on hsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hsp_hash
  import hsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [1:0]  mode,
  input  wire logic [31:0] key,
  output logic             done,
  output logic [31:0]      hash
);

  logic [31:0] a, b, c;
  logic [2:0]  cnt;
  logic [1:0]  mode_q;
  logic        busy;

  logic [31:0] mx, my, arx, mul_k, prod;
  logic [63:0] yy;
  logic        last;

  always_comb begin
    unique case (cnt)
      3'd0, 3'd3, 3'd6: begin mx = c; my = b; end
      3'd1, 3'd4:       begin mx = a; my = c; end
      default:          begin mx = b; my = a; end
    endcase
    yy  = {my, my} << lk3_rot(cnt);
    arx = (mx ^ my) - yy[63:32];
  end

  always_comb begin
    if (mode_q == HM_MURMUR) begin
      mul_k = (cnt == 3'd1) ? MUR_C1 : MUR_C2;
    end else begin
      mul_k = MA_MUL;
    end
    prod = a * mul_k;
  end

  always_comb begin
    unique case (mode_q)
      HM_LOOKUP3: last = (cnt == 3'd6);
      HM_MURMUR:  last = (cnt == 3'd4);
      default:    last = (cnt == 3'd1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
      end else if (last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode_q <= mode;
      cnt    <= 3'd0;
      a      <= (mode == HM_LOOKUP3) ? LK3_INIT + key : key;
      b      <= LK3_INIT;
      c      <= LK3_INIT;
    end else if (busy) begin
      cnt <= cnt + 3'd1;
      unique case (mode_q)
        HM_LOOKUP3: begin
          unique case (cnt)
            3'd0, 3'd3, 3'd6: c <= arx;
            3'd1, 3'd4:       a <= arx;
            default:          b <= arx;
          endcase
        end
        HM_MURMUR: begin
          unique case (cnt)
            3'd0, 3'd4: a <= a ^ (a >> 16);
            3'd2:       a <= a ^ (a >> 13);
            default:    a <= prod;
          endcase
        end
        default: begin
          a <= (cnt == 3'd0) ? prod : a + MA_ADD;
        end
      endcase
    end
  end

  assign hash = (mode_q == HM_LOOKUP3) ? c : a;

endmodule
`default_nettype wire

### hw/rtl/hsp_mod.sv
// Restoring remainder unit: one dividend bit per cycle.
// Depends on hsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hsp_mod
  import hsp_pkg::*;
#(
  parameter int CW = 11,
  parameter int SW = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [31:0]   dividend,
  input  wire logic [CW-1:0] divisor,
  output logic               done,
  output logic [SW-1:0]      rem
);

  logic [31:0]   d;
  logic [CW-1:0] r;
  logic [4:0]    cnt;
  logic          busy;
  logic [CW:0]   t;

  assign t = {r, d[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 5'd31);
      if (start) begin
        busy <= 1'b1;
      end else if (cnt == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d   <= dividend;
      r   <= '0;
      cnt <= 5'd0;
    end else if (busy) begin
      d   <= d << 1;
      cnt <= cnt + 5'd1;
      if (t >= {1'b0, divisor}) begin
        r <= CW'(t - {1'b0, divisor});
      end else begin
        r <= CW'(t);
      end
    end
  end

  assign rem = SW'(r);

endmodule
`default_nettype wire

### hw/rtl/int_hash_set_probe_engine.sv
// Top level of the hash set probe engine: sequencer, slot memory, counters.
// Depends on hsp_pkg, hsp_hash, hsp_mod and the defines header.
//
// Usage: present a word on item and raise start while busy is low; it is
// taken at that clock edge. busy then stays high until the result word
// appears on result with done high for exactly one cycle; the receiver
// cannot stall it and must take it then. Configuration is written through
// cfg_we, cfg_idx and cfg_wdata while busy is low, in one cycle, no read-back.
// An add or query loads the word (an add over the load limit is refused
// there), hashes it, takes the remainder of the hash by the slot count,
// reduces the probe stride below the slot count, then reads and checks
// slots in turn. A clear sweeps all slots; an unused opcode keeps busy low.
// After reset the engine sweeps every slot of the slot memory with busy
// high, then goes idle; no result word is produced for that sweep.
`timescale 1ns / 1ps
`default_nettype none
`include "int_hash_set_probe_engine_defines.svh"
module int_hash_set_probe_engine
  import hsp_pkg::*;
#(
  parameter int MAX_SLOTS    = 1024,
  parameter int PROBE_STRIDE = 13
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire hsp_item_t        item,
  output logic                  busy,
  output logic                  done,
  output hsp_result_t           result,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_idx,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int SW = $clog2(MAX_SLOTS);
  localparam int XW = CW + 7;
  localparam logic [SW-1:0] LAST_IDX = SW'(MAX_SLOTS - 1);

  hsp_state_t state, state_next;

  logic [1:0]  hash_mode;
  logic [10:0] slot_count;
  logic [8:0]  load_limit;

  logic [CW-1:0] cap, cap_q, count, count_next, pcnt, pcnt_next;
  logic [1:0]    op_q;
  logic [31:0]   val_q, h_q, sig, sig_next, coll, coll_next;
  logic [SW-1:0] pos, pos_next, sweep_idx, mod_rem, mem_waddr;
  logic [XW-1:0] stride, psum;
  logic          sweep_report;

  logic [32:0] mem [MAX_SLOTS];
  logic [32:0] rdata, mem_wdata;
  logic        mem_we;

  logic        hash_start, hash_done, mod_start, mod_done;
  logic [31:0] hash_out;
  logic        finish, overload, occ, match, probe_end;
  logic [1:0]  fin_status;
  logic [CW+8:0] load_lhs, load_rhs;

  always_comb begin
    if (slot_count == 11'd0) begin
      cap = CW'(1);
    end else if (int'(slot_count) > MAX_SLOTS) begin
      cap = CW'(MAX_SLOTS);
    end else begin
      cap = CW'(slot_count);
    end
  end

  assign load_lhs  = {1'b0, count, 8'b0};
  assign load_rhs  = (CW+9)'(cap_q) * (CW+9)'(load_limit);
  assign overload  = (op_q == OP_ADD) && (load_lhs > load_rhs);
  assign occ       = rdata[32];
  assign match     = occ && (rdata[31:0] == val_q);
  assign probe_end = (pcnt == cap_q - CW'(1));
  assign psum      = XW'(pos) + stride;
  assign busy      = (state != S_IDLE);

  hsp_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .mode  (hash_mode),
    .key   (val_q),
    .done  (hash_done),
    .hash  (hash_out)
  );

  hsp_mod #(.CW(CW), .SW(SW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (hash_out),
    .divisor  (cap_q),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (item.operation == OP_ADD || item.operation == OP_QUERY) begin
            state_next = S_LOAD;
          end else if (item.operation == OP_CLEAR) begin
            state_next = S_SWEEP;
          end
        end
      end
      S_SWEEP:  if (sweep_idx == LAST_IDX) state_next = S_IDLE;
      S_LOAD:   state_next = overload ? S_IDLE : S_HASH;
      S_HASH:   if (hash_done) state_next = S_MOD;
      S_MOD:    if (mod_done) state_next = S_STRIDE;
      S_STRIDE: if (stride < XW'(cap_q)) state_next = S_READ;
      S_READ:   state_next = S_CHECK;
      S_CHECK: begin
        if (!occ || match || probe_end) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_READ;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    hash_start = 1'b0;
    mod_start  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = pos;
    mem_wdata  = {1'b1, val_q};
    finish     = 1'b0;
    fin_status = ST_FULL;
    count_next = count;
    sig_next   = sig;
    coll_next  = coll;
    pcnt_next  = pcnt;
    pos_next   = pos;
    unique case (state)
      S_IDLE: begin
        if (start && item.operation != OP_ADD && item.operation != OP_QUERY
            && item.operation != OP_CLEAR) begin
          finish = 1'b1;
        end
      end
      S_SWEEP: begin
        mem_we     = 1'b1;
        mem_waddr  = sweep_idx;
        mem_wdata  = {1'b0, val_q};
        count_next = '0;
        sig_next   = '0;
        finish     = sweep_report && (sweep_idx == LAST_IDX);
        fin_status = ST_INSERTED;
      end
      S_LOAD: begin
        hash_start = !overload;
        finish     = overload;
      end
      S_HASH:  mod_start = hash_done;
      S_MOD: begin
        pcnt_next = '0;
        if (mod_done) begin
          pos_next = mod_rem;
        end
      end
      S_CHECK: begin
        if (!occ) begin
          finish = 1'b1;
          if (op_q == OP_ADD) begin
            mem_we     = 1'b1;
            count_next = count + CW'(1);
            sig_next   = sig ^ h_q;
            fin_status = ST_INSERTED;
          end else begin
            fin_status = ST_NOT_PRESENT;
          end
        end else if (match) begin
          finish     = 1'b1;
          fin_status = ST_PRESENT;
        end else begin
          if (op_q == OP_ADD) begin
            coll_next = coll + 32'd1;
          end
          finish     = probe_end;
          fin_status = (op_q == OP_ADD) ? ST_FULL : ST_NOT_PRESENT;
          pcnt_next  = pcnt + CW'(1);
          pos_next   = (psum >= XW'(cap_q)) ? SW'(psum - XW'(cap_q)) : SW'(psum);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      sweep_idx    <= '0;
      sweep_report <= 1'b0;
      count        <= '0;
      sig          <= '0;
      coll         <= '0;
      done         <= 1'b0;
      hash_mode    <= HM_MULADD;
      slot_count   <= 11'd1021;
      load_limit   <= 9'd192;
    end else begin
      state <= state_next;
      count <= count_next;
      sig   <= sig_next;
      coll  <= coll_next;
      done  <= finish;
      if (state == S_SWEEP) begin
        sweep_idx <= sweep_idx + SW'(1);
      end else begin
        sweep_idx <= '0;
      end
      if (state == S_IDLE && start) begin
        sweep_report <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_HASH_MODE:  hash_mode  <= cfg_wdata[1:0];
          CFG_SLOT_COUNT: slot_count <= cfg_wdata[10:0];
          CFG_LOAD_LIMIT: load_limit <= cfg_wdata[8:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pos  <= pos_next;
    pcnt <= pcnt_next;
    if (finish) begin
      result.status          <= fin_status;
      result.element_count   <= 11'(count_next);
      result.set_signature   <= sig_next;
      result.collision_total <= coll_next;
    end
    if (state == S_IDLE && start) begin
      op_q  <= item.operation;
      val_q <= item.value;
      cap_q <= cap;
    end
    if (state == S_HASH && hash_done) begin
      h_q <= hash_out;
    end
    if (state == S_MOD) begin
      stride <= XW'(PROBE_STRIDE);
    end else if (state == S_STRIDE && stride >= XW'(cap_q)) begin
      stride <= stride - XW'(cap_q);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[pos];
  end

  `HSP_ASSERT_NOW(a_count_range, 1'b1, int'(count) <= MAX_SLOTS, "count beyond slots")
  `HSP_ASSERT_NOW(a_pos_range, state == S_CHECK, CW'(pos) < cap_q, "probe slot out of range")
  `HSP_ASSERT_NEXT(a_accept, start && !busy, busy || done, "accepted word dropped")
  `HSP_ASSERT_NEXT(a_done_idle, finish, state == S_IDLE, "result while still working")

endmodule
`default_nettype wire
